>>> rtl/core/clc_pkg.sv
// Shared types and codes for the load/logic/compare CPU subset.
`timescale 1ns / 1ps

package clc_pkg;

  // Item commands
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_OPCODE = 2'd1;
  localparam logic [1:0] STAT_FETCH  = 2'd2;

  // Memory access request from the sequencer
  typedef struct packed {
    logic        valid;
    logic        wr;
    logic [15:0] addr;
    logic [7:0]  data;
  } mem_req_t;

  // Memory unit response
  typedef struct packed {
    logic       busy;
    logic       done;
    logic [7:0] rdata;
  } mem_rsp_t;

endpackage

>>> rtl/core/clc_mem.sv
// Byte memory with address folding, pipelined access and a clearing sweep after reset.
`timescale 1ns / 1ps

module clc_mem #(
  parameter int MEM_BYTES = 65536
) (
  input  logic              clk,
  input  logic              rst,
  input  clc_pkg::mem_req_t req,
  output clc_pkg::mem_rsp_t rsp
);
  import clc_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);
  localparam longint unsigned RECIP_L = (64'd1 << 32) / MEM_BYTES;
  localparam logic [24:0] RECIP = 25'(RECIP_L);
  localparam logic [16:0] MEM_M = 17'(MEM_BYTES);
  localparam logic [AW-1:0] LAST_IDX = AW'(MEM_BYTES - 1);

  logic [7:0] mem [MEM_BYTES];

  // stage 1: request capture
  logic        v1;
  logic        wr1;
  logic [15:0] addr1;
  logic [7:0]  data1;
  // stage 2: quotient estimate
  logic        v2;
  logic        wr2;
  logic [15:0] addr2;
  logic [7:0]  data2;
  logic [7:0]  q2;
  // stage 3: read data
  logic        v3;
  logic [7:0]  rdata;

  logic          clearing;
  logic [AW-1:0] clr_idx;

  logic [40:0]   prod;
  logic [24:0]   qm;
  logic [16:0]   rem_raw;
  logic [16:0]   rem;
  logic [AW-1:0] idx;
  logic [AW-1:0] ram_addr;
  logic          ram_we;
  logic [7:0]    ram_wdata;

  // floor(a / M) is q2 or q2 + 1; one correction step finishes the remainder
  assign prod    = {25'd0, addr1} * {16'd0, RECIP};
  assign qm      = {17'd0, q2} * {8'd0, MEM_M};
  assign rem_raw = {1'b0, addr2} - qm[16:0];
  assign rem     = (rem_raw >= MEM_M) ? (rem_raw - MEM_M) : rem_raw;
  assign idx     = rem[AW-1:0];

  assign ram_addr  = clearing ? clr_idx : idx;
  assign ram_we    = clearing || (v2 && wr2);
  assign ram_wdata = clearing ? 8'h00 : data2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else begin
      v1 <= req.valid;
      v2 <= v1;
      v3 <= v2;
      if (clearing) begin
        if (clr_idx == LAST_IDX) begin
          clearing <= 1'b0;
        end else begin
          clr_idx <= clr_idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    wr1   <= req.wr;
    addr1 <= req.addr;
    data1 <= req.data;
    wr2   <= wr1;
    addr2 <= addr1;
    data2 <= data1;
    q2    <= prod[39:32];
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      mem[ram_addr] <= ram_wdata;
    end
    rdata <= mem[ram_addr];
  end

  assign rsp.busy  = clearing;
  assign rsp.done  = v3;
  assign rsp.rdata = rdata;

endmodule

>>> rtl/core/cpu_load_logic_compare_subset.sv
// Top level: registers, instruction sequencer, configuration port and result register.
`timescale 1ns / 1ps

// Executes AND, EOR, ORA, LDA, LDX, LDY and CMP in all standard addressing
// modes over a byte memory of MEM_BYTES entries, one item at a time. Each item
// (memory write, start, step) yields one result with the status and the
// register and flag values after it. Every memory access runs through one
// shared memory unit and passes its request register, address fold by
// reciprocal multiply and registered RAM read, so the item time is set by
// the number of accesses: a step makes two for an immediate operand and up
// to five for the indirect modes, a memory write one, start and the unused
// command none, plus any stall on the result side.
// After reset the memory is swept to zero, one byte a cycle, over all
// MEM_BYTES entries; no item is accepted until the sweep ends, while
// configuration writes are taken throughout.
module cpu_load_logic_compare_subset #(
  parameter int MEM_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // item input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [15:0] mem_addr,
  input  logic [7:0]  mem_data,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [7:0]  acc_out,
  output logic [7:0]  x_out,
  output logic [7:0]  y_out,
  output logic [15:0] pc_out,
  output logic        neg_flag,
  output logic        zero_flag,
  output logic        carry_flag
);
  import clc_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_OP   = 4'd1;
  localparam logic [3:0] ST_B0   = 4'd2;
  localparam logic [3:0] ST_B1   = 4'd3;
  localparam logic [3:0] ST_PL   = 4'd4;
  localparam logic [3:0] ST_PH   = 4'd5;
  localparam logic [3:0] ST_DATA = 4'd6;
  localparam logic [3:0] ST_WR   = 4'd7;
  localparam logic [3:0] ST_EXEC = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  localparam logic [3:0] M_IMM  = 4'd0;
  localparam logic [3:0] M_ZP   = 4'd1;
  localparam logic [3:0] M_ZPX  = 4'd2;
  localparam logic [3:0] M_ZPY  = 4'd3;
  localparam logic [3:0] M_ABS  = 4'd4;
  localparam logic [3:0] M_ABSX = 4'd5;
  localparam logic [3:0] M_ABSY = 4'd6;
  localparam logic [3:0] M_INDX = 4'd7;
  localparam logic [3:0] M_INDY = 4'd8;

  localparam logic [2:0] K_LDA = 3'd0;
  localparam logic [2:0] K_LDX = 3'd1;
  localparam logic [2:0] K_LDY = 3'd2;
  localparam logic [2:0] K_AND = 3'd3;
  localparam logic [2:0] K_EOR = 3'd4;
  localparam logic [2:0] K_ORA = 3'd5;
  localparam logic [2:0] K_CMP = 3'd6;

  // operation field of the group-one opcodes
  localparam logic [2:0] G_ORA = 3'd0;
  localparam logic [2:0] G_AND = 3'd1;
  localparam logic [2:0] G_EOR = 3'd2;
  localparam logic [2:0] G_LDA = 3'd5;
  localparam logic [2:0] G_CMP = 3'd6;

  localparam logic [7:0] OP_LDX_IMM  = 8'hA2;
  localparam logic [7:0] OP_LDX_ZP   = 8'hA6;
  localparam logic [7:0] OP_LDX_ZPY  = 8'hB6;
  localparam logic [7:0] OP_LDX_ABS  = 8'hAE;
  localparam logic [7:0] OP_LDX_ABSY = 8'hBE;
  localparam logic [7:0] OP_LDY_IMM  = 8'hA0;
  localparam logic [7:0] OP_LDY_ZP   = 8'hA4;
  localparam logic [7:0] OP_LDY_ZPX  = 8'hB4;
  localparam logic [7:0] OP_LDY_ABS  = 8'hAC;
  localparam logic [7:0] OP_LDY_ABSX = 8'hBC;

  localparam logic [2:0] REG_BASE   = 3'd0;
  localparam logic [2:0] REG_LENGTH = 3'd4;

  typedef struct packed {
    logic       ok;
    logic [2:0] kind;
    logic [3:0] mode;
  } dec_t;

  function automatic dec_t decode_op(input logic [7:0] op);
    dec_t d;
    d.ok   = 1'b1;
    d.kind = K_ORA;
    d.mode = M_IMM;
    if (op[1:0] == 2'b01) begin
      case (op[4:2])
        3'd0:    d.mode = M_INDX;
        3'd1:    d.mode = M_ZP;
        3'd2:    d.mode = M_IMM;
        3'd3:    d.mode = M_ABS;
        3'd4:    d.mode = M_INDY;
        3'd5:    d.mode = M_ZPX;
        3'd6:    d.mode = M_ABSY;
        default: d.mode = M_ABSX;
      endcase
      case (op[7:5])
        G_ORA:   d.kind = K_ORA;
        G_AND:   d.kind = K_AND;
        G_EOR:   d.kind = K_EOR;
        G_LDA:   d.kind = K_LDA;
        G_CMP:   d.kind = K_CMP;
        default: d.ok = 1'b0;
      endcase
    end else begin
      case (op)
        OP_LDX_IMM:  begin d.kind = K_LDX; d.mode = M_IMM;  end
        OP_LDX_ZP:   begin d.kind = K_LDX; d.mode = M_ZP;   end
        OP_LDX_ZPY:  begin d.kind = K_LDX; d.mode = M_ZPY;  end
        OP_LDX_ABS:  begin d.kind = K_LDX; d.mode = M_ABS;  end
        OP_LDX_ABSY: begin d.kind = K_LDX; d.mode = M_ABSY; end
        OP_LDY_IMM:  begin d.kind = K_LDY; d.mode = M_IMM;  end
        OP_LDY_ZP:   begin d.kind = K_LDY; d.mode = M_ZP;   end
        OP_LDY_ZPX:  begin d.kind = K_LDY; d.mode = M_ZPX;  end
        OP_LDY_ABS:  begin d.kind = K_LDY; d.mode = M_ABS;  end
        OP_LDY_ABSX: begin d.kind = K_LDY; d.mode = M_ABSX; end
        default:     d.ok = 1'b0;
      endcase
    end
    return d;
  endfunction

  // configuration
  logic [15:0] base;
  logic [16:0] len;

  // architectural state
  logic [7:0]  acc, acc_next;
  logic [7:0]  xr, xr_next;
  logic [7:0]  yr, yr_next;
  logic [15:0] pc, pc_next;
  logic        flag_n, flag_n_next;
  logic        flag_z, flag_z_next;
  logic        flag_c, flag_c_next;

  // sequencer working registers
  logic [3:0]  state, state_next;
  logic [15:0] pc_w, pc_w_next;
  logic [7:0]  b0, b0_next;
  logic [7:0]  lo, lo_next;
  logic [7:0]  ptr, ptr_next;
  logic [7:0]  m, m_next;
  logic [2:0]  kind, kind_next;
  logic [3:0]  mode, mode_next;
  logic [1:0]  res_status, res_status_next;

  mem_req_t req;
  mem_rsp_t rsp;

  logic [17:0] fetch_end;
  logic        pc_ok;
  logic        pc_w_ok;
  dec_t        op_dec;
  logic [7:0]  zp_sum;
  logic [15:0] idx16;
  logic [15:0] ea_sum;
  logic [8:0]  cmp_diff;
  logic [7:0]  logic_res;
  logic        out_load;
  logic        cfg_wr;

  clc_mem #(
    .MEM_BYTES(MEM_BYTES)
  ) u_mem (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = paddr[2] ? {15'd0, len} : {16'd0, base};

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
      len  <= '0;
    end else if (cfg_wr) begin
      if ((paddr & REG_LENGTH) == REG_LENGTH) begin
        len <= pwdata[16:0];
      end else if ((paddr & REG_LENGTH) == REG_BASE) begin
        base <= pwdata[15:0];
      end
    end
  end

  assign in_stall = (state != ST_IDLE) || rsp.busy;

  assign fetch_end = {2'b00, base} + {1'b0, len};
  assign pc_ok     = {2'b00, pc} < fetch_end;
  assign pc_w_ok   = {2'b00, pc_w} < fetch_end;
  assign op_dec    = decode_op(rsp.rdata);
  assign zp_sum    = rsp.rdata + ((mode == M_ZPY) ? yr : xr);

  // one 16-bit adder forms both the absolute-indexed and indirect-indexed addresses
  always_comb begin
    if (mode == M_ABSX) begin
      idx16 = {8'h00, xr};
    end else if (mode == M_ABSY || mode == M_INDY) begin
      idx16 = {8'h00, yr};
    end else begin
      idx16 = 16'h0000;
    end
  end
  assign ea_sum = {rsp.rdata, (state == ST_B1) ? b0 : lo} + idx16;

  assign cmp_diff = {1'b0, acc} - {1'b0, m};

  always_comb begin
    case (kind)
      K_AND:   logic_res = acc & m;
      K_EOR:   logic_res = acc ^ m;
      K_ORA:   logic_res = acc | m;
      default: logic_res = m;
    endcase
  end

  always_comb begin
    state_next      = state;
    pc_w_next       = pc_w;
    b0_next         = b0;
    lo_next         = lo;
    ptr_next        = ptr;
    m_next          = m;
    kind_next       = kind;
    mode_next       = mode;
    res_status_next = res_status;
    acc_next        = acc;
    xr_next         = xr;
    yr_next         = yr;
    pc_next         = pc;
    flag_n_next     = flag_n;
    flag_z_next     = flag_z;
    flag_c_next     = flag_c;
    req             = '0;

    case (state)
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          res_status_next = STAT_OK;
          case (cmd)
            CMD_WRITE: begin
              req.valid  = 1'b1;
              req.wr     = 1'b1;
              req.addr   = mem_addr;
              req.data   = mem_data;
              state_next = ST_WR;
            end
            CMD_START: begin
              pc_next    = base;
              state_next = ST_DONE;
            end
            CMD_STEP: begin
              if (pc_ok) begin
                req.valid  = 1'b1;
                req.addr   = pc;
                pc_w_next  = pc + 16'd1;
                state_next = ST_OP;
              end else begin
                res_status_next = STAT_FETCH;
                state_next      = ST_DONE;
              end
            end
            default: state_next = ST_DONE;
          endcase
        end
      end

      ST_WR: begin
        if (rsp.done) begin
          state_next = ST_DONE;
        end
      end

      ST_OP: begin
        if (rsp.done) begin
          kind_next = op_dec.kind;
          mode_next = op_dec.mode;
          if (!op_dec.ok) begin
            res_status_next = STAT_OPCODE;
            state_next      = ST_DONE;
          end else if (!pc_w_ok) begin
            res_status_next = STAT_FETCH;
            state_next      = ST_DONE;
          end else begin
            req.valid  = 1'b1;
            req.addr   = pc_w;
            pc_w_next  = pc_w + 16'd1;
            state_next = ST_B0;
          end
        end
      end

      ST_B0: begin
        if (rsp.done) begin
          b0_next = rsp.rdata;
          case (mode)
            M_ABS, M_ABSX, M_ABSY: begin
              if (pc_w_ok) begin
                req.valid  = 1'b1;
                req.addr   = pc_w;
                pc_w_next  = pc_w + 16'd1;
                state_next = ST_B1;
              end else begin
                res_status_next = STAT_FETCH;
                state_next      = ST_DONE;
              end
            end
            M_IMM: begin
              m_next     = rsp.rdata;
              state_next = ST_EXEC;
            end
            M_ZP: begin
              req.valid  = 1'b1;
              req.addr   = {8'h00, rsp.rdata};
              state_next = ST_DATA;
            end
            M_ZPX, M_ZPY: begin
              req.valid  = 1'b1;
              req.addr   = {8'h00, zp_sum};
              state_next = ST_DATA;
            end
            M_INDX: begin
              ptr_next   = zp_sum;
              req.valid  = 1'b1;
              req.addr   = {8'h00, zp_sum};
              state_next = ST_PL;
            end
            M_INDY: begin
              ptr_next   = rsp.rdata;
              req.valid  = 1'b1;
              req.addr   = {8'h00, rsp.rdata};
              state_next = ST_PL;
            end
            default: begin
              res_status_next = STAT_OPCODE;
              state_next      = ST_DONE;
            end
          endcase
        end
      end

      ST_B1: begin
        if (rsp.done) begin
          req.valid  = 1'b1;
          req.addr   = ea_sum;
          state_next = ST_DATA;
        end
      end

      ST_PL: begin
        if (rsp.done) begin
          // pointer high byte wraps within page zero
          lo_next    = rsp.rdata;
          req.valid  = 1'b1;
          req.addr   = {8'h00, ptr + 8'd1};
          state_next = ST_PH;
        end
      end

      ST_PH: begin
        if (rsp.done) begin
          req.valid  = 1'b1;
          req.addr   = ea_sum;
          state_next = ST_DATA;
        end
      end

      ST_DATA: begin
        if (rsp.done) begin
          m_next     = rsp.rdata;
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        pc_next = pc_w;
        if (kind == K_CMP) begin
          flag_c_next = !cmp_diff[8];
          flag_z_next = (acc == m);
          flag_n_next = cmp_diff[7];
        end else begin
          flag_z_next = (logic_res == 8'h00);
          flag_n_next = logic_res[7];
          case (kind)
            K_LDX:   xr_next  = logic_res;
            K_LDY:   yr_next  = logic_res;
            default: acc_next = logic_res;
          endcase
        end
        state_next = ST_DONE;
      end

      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      acc    <= '0;
      xr     <= '0;
      yr     <= '0;
      pc     <= '0;
      flag_n <= 1'b0;
      flag_z <= 1'b0;
      flag_c <= 1'b0;
    end else begin
      state  <= state_next;
      acc    <= acc_next;
      xr     <= xr_next;
      yr     <= yr_next;
      pc     <= pc_next;
      flag_n <= flag_n_next;
      flag_z <= flag_z_next;
      flag_c <= flag_c_next;
    end
  end

  always_ff @(posedge clk) begin
    pc_w       <= pc_w_next;
    b0         <= b0_next;
    lo         <= lo_next;
    ptr        <= ptr_next;
    m          <= m_next;
    kind       <= kind_next;
    mode       <= mode_next;
    res_status <= res_status_next;
  end

  // result register: refilled once the previous transfer has gone
  assign out_load = (state == ST_DONE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status     <= res_status;
      acc_out    <= acc;
      x_out      <= xr;
      y_out      <= yr;
      pc_out     <= pc;
      neg_flag   <= flag_n;
      zero_flag  <= flag_z;
      carry_flag <= flag_c;
    end
  end

endmodule

>>> bench/clc_state_tracker.sv
// Opcode codes for the bench, and the monitor that predicts and checks every result.
`timescale 1ns / 1ps

package clc_tb_pkg;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [2:0] REG_PROGRAM_BASE   = 3'd0;
  localparam logic [2:0] REG_PROGRAM_LENGTH = 3'd4;

  // opcode bits 1:0 of the ORA/AND/EOR/LDA/CMP group, and its bits 7:5
  localparam logic [1:0] GROUP_ONE = 2'b01;
  localparam logic [2:0] GRP_ORA   = 3'd0;
  localparam logic [2:0] GRP_AND   = 3'd1;
  localparam logic [2:0] GRP_EOR   = 3'd2;
  localparam logic [2:0] GRP_LDA   = 3'd5;
  localparam logic [2:0] GRP_CMP   = 3'd6;

  localparam logic [7:0] OP_LDX_IMM  = 8'hA2;
  localparam logic [7:0] OP_LDX_ZP   = 8'hA6;
  localparam logic [7:0] OP_LDX_ZPY  = 8'hB6;
  localparam logic [7:0] OP_LDX_ABS  = 8'hAE;
  localparam logic [7:0] OP_LDX_ABSY = 8'hBE;
  localparam logic [7:0] OP_LDY_IMM  = 8'hA0;
  localparam logic [7:0] OP_LDY_ZP   = 8'hA4;
  localparam logic [7:0] OP_LDY_ZPX  = 8'hB4;
  localparam logic [7:0] OP_LDY_ABS  = 8'hAC;
  localparam logic [7:0] OP_LDY_ABSX = 8'hBC;
  localparam logic [7:0] OP_LDA_ZPX  = 8'hB5;
  localparam logic [7:0] OP_CMP_IMM  = 8'hC9;
  localparam logic [7:0] OP_ORA_INDX = 8'h01;
  localparam logic [7:0] OP_AND_IMM  = 8'h29;
  localparam logic [7:0] OP_EOR_IMM  = 8'h49;

  typedef enum logic [2:0] {
    OPK_LDA, OPK_LDX, OPK_LDY, OPK_AND, OPK_EOR, OPK_ORA, OPK_CMP
  } op_kind_e;

  // group-one modes carry the value of opcode bits 4:2
  typedef enum logic [3:0] {
    AM_INDX = 4'd0, AM_ZP = 4'd1, AM_IMM = 4'd2, AM_ABS = 4'd3, AM_INDY = 4'd4,
    AM_ZPX = 4'd5, AM_ABSY = 4'd6, AM_ABSX = 4'd7, AM_ZPY = 4'd8
  } addr_mode_e;

  typedef struct packed {
    logic       ok;
    op_kind_e   kind;
    addr_mode_e mode;
  } op_decode_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  acc;
    logic [7:0]  xr;
    logic [7:0]  yr;
    logic [15:0] pc;
    logic        n;
    logic        z;
    logic        c;
  } cpu_view_t;

  function automatic op_decode_t decode_op(input logic [7:0] op);
    op_decode_t d;
    d.ok   = 1'b1;
    d.kind = OPK_LDA;
    d.mode = AM_IMM;
    if (op[1:0] == GROUP_ONE) begin
      d.mode = addr_mode_e'({1'b0, op[4:2]});
      case (op[7:5])
        GRP_ORA: d.kind = OPK_ORA;
        GRP_AND: d.kind = OPK_AND;
        GRP_EOR: d.kind = OPK_EOR;
        GRP_LDA: d.kind = OPK_LDA;
        GRP_CMP: d.kind = OPK_CMP;
        default: d.ok = 1'b0;
      endcase
    end else begin
      case (op)
        OP_LDX_IMM:  begin d.kind = OPK_LDX; d.mode = AM_IMM;  end
        OP_LDX_ZP:   begin d.kind = OPK_LDX; d.mode = AM_ZP;   end
        OP_LDX_ZPY:  begin d.kind = OPK_LDX; d.mode = AM_ZPY;  end
        OP_LDX_ABS:  begin d.kind = OPK_LDX; d.mode = AM_ABS;  end
        OP_LDX_ABSY: begin d.kind = OPK_LDX; d.mode = AM_ABSY; end
        OP_LDY_IMM:  begin d.kind = OPK_LDY; d.mode = AM_IMM;  end
        OP_LDY_ZP:   begin d.kind = OPK_LDY; d.mode = AM_ZP;   end
        OP_LDY_ZPX:  begin d.kind = OPK_LDY; d.mode = AM_ZPX;  end
        OP_LDY_ABS:  begin d.kind = OPK_LDY; d.mode = AM_ABS;  end
        OP_LDY_ABSX: begin d.kind = OPK_LDY; d.mode = AM_ABSX; end
        default: d.ok = 1'b0;
      endcase
    end
    return d;
  endfunction

  function automatic logic is_absolute(input addr_mode_e m);
    return (m == AM_ABS) || (m == AM_ABSX) || (m == AM_ABSY);
  endfunction

endpackage

module clc_state_tracker #(
  parameter int MEM_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [15:0] mem_addr,
  input  logic [7:0]  mem_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  status,
  input  logic [7:0]  acc_out,
  input  logic [7:0]  x_out,
  input  logic [7:0]  y_out,
  input  logic [15:0] pc_out,
  input  logic        neg_flag,
  input  logic        zero_flag,
  input  logic        carry_flag,
  output int          fail_count,
  output int          pending,
  output int          item_count,
  output int          step_count,
  output int          opcode_errs,
  output int          fetch_errs
);
  import clc_pkg::*;
  import clc_tb_pkg::*;

  logic [7:0]  acc_reg, x_reg, y_reg;
  logic [15:0] prog_pc;
  logic        flag_n, flag_z, flag_c;
  logic [15:0] cfg_base;
  logic [16:0] cfg_len;
  bit   [7:0]  mem_img [MEM_BYTES];
  cpu_view_t   result_q [$];
  int          result_count;

  function automatic logic [7:0] mem_rd(input logic [15:0] a);
    return mem_img[a % MEM_BYTES];
  endfunction

  // a pc below the base is never refused
  function automatic logic in_program(input logic [15:0] a);
    return {2'b00, a} < ({2'b00, cfg_base} + {1'b0, cfg_len});
  endfunction

  task automatic exec_step(output logic [1:0] st);
    logic [15:0] pc, ea;
    logic [7:0]  op, b0, b1, m, r, p, p_hi;
    op_decode_t  d;
    st = STAT_OK;
    pc = prog_pc;
    if (!in_program(pc)) begin
      st = STAT_FETCH;
      return;
    end
    op = mem_rd(pc);
    pc = pc + 16'd1;
    d = decode_op(op);
    if (!d.ok) begin
      st = STAT_OPCODE;
      return;
    end
    if (!in_program(pc)) begin
      st = STAT_FETCH;
      return;
    end
    b0 = mem_rd(pc);
    pc = pc + 16'd1;
    b1 = 8'h00;
    if (is_absolute(d.mode)) begin
      if (!in_program(pc)) begin
        st = STAT_FETCH;
        return;
      end
      b1 = mem_rd(pc);
      pc = pc + 16'd1;
    end
    // zero-page sums and pointer fetches stay in page zero
    p = b0 + x_reg;
    case (d.mode)
      AM_ZP:   ea = {8'h00, b0};
      AM_ZPX:  ea = {8'h00, p};
      AM_ZPY:  begin
        p  = b0 + y_reg;
        ea = {8'h00, p};
      end
      AM_ABS:  ea = {b1, b0};
      AM_ABSX: ea = {b1, b0} + {8'h00, x_reg};
      AM_ABSY: ea = {b1, b0} + {8'h00, y_reg};
      AM_INDX: begin
        p_hi = p + 8'd1;
        ea   = {mem_rd({8'h00, p_hi}), mem_rd({8'h00, p})};
      end
      AM_INDY: begin
        p_hi = b0 + 8'd1;
        ea   = {mem_rd({8'h00, p_hi}), mem_rd({8'h00, b0})} + {8'h00, y_reg};
      end
      default: ea = 16'h0000;
    endcase
    m = (d.mode == AM_IMM) ? b0 : mem_rd(ea);
    if (d.kind == OPK_CMP) begin
      r      = acc_reg - m;
      flag_c = (acc_reg >= m);
      flag_z = (acc_reg == m);
      flag_n = r[7];
    end else begin
      case (d.kind)
        OPK_LDA: begin r = m; acc_reg = r; end
        OPK_LDX: begin r = m; x_reg = r; end
        OPK_LDY: begin r = m; y_reg = r; end
        OPK_AND: begin r = acc_reg & m; acc_reg = r; end
        OPK_EOR: begin r = acc_reg ^ m; acc_reg = r; end
        default: begin r = acc_reg | m; acc_reg = r; end
      endcase
      flag_z = (r == 8'h00);
      flag_n = r[7];
    end
    prog_pc = pc;
  endtask

  task automatic apply_item(input logic [1:0] c, input logic [15:0] a, input logic [7:0] d,
                            output cpu_view_t v);
    logic [1:0] st;
    st = STAT_OK;
    case (c)
      CMD_WRITE: mem_img[a % MEM_BYTES] = d;
      CMD_START: prog_pc = cfg_base;
      CMD_STEP:  exec_step(st);
      default: ;
    endcase
    v = '{st, acc_reg, x_reg, y_reg, prog_pc, flag_n, flag_z, flag_c};
  endtask

  task automatic report_mismatch(input string field, input int unsigned got_v,
                                 input int unsigned want_v);
    if (fail_count < 30)
      $display("result %0d: %s is %0h, predicted %0h", result_count, field, got_v, want_v);
    fail_count++;
  endtask

  always @(posedge clk) begin
    cpu_view_t got, want;
    if (rst) begin
      acc_reg = '0;
      x_reg = '0;
      y_reg = '0;
      prog_pc = '0;
      {flag_n, flag_z, flag_c} = 3'b000;
      cfg_base = '0;
      cfg_len = '0;
      result_q.delete();
      result_count = 0;
      fail_count = 0;
      pending = 0;
      item_count = 0;
      step_count = 0;
      opcode_errs = 0;
      fetch_errs = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == REG_PROGRAM_BASE)
          cfg_base = pwdata[15:0];
        else if (paddr == REG_PROGRAM_LENGTH)
          cfg_len = pwdata[16:0];
      end
      // results go first: one taken at the same edge belongs to an older transfer
      if (out_valid && !out_stall) begin
        got = '{status, acc_out, x_out, y_out, pc_out, neg_flag, zero_flag, carry_flag};
        if (result_q.size() == 0) begin
          report_mismatch("result with none pending, pc", got.pc, 0);
        end else begin
          want = result_q.pop_front();
          if (got.status !== want.status) report_mismatch("status", got.status, want.status);
          if (got.acc !== want.acc) report_mismatch("acc_out", got.acc, want.acc);
          if (got.xr !== want.xr) report_mismatch("x_out", got.xr, want.xr);
          if (got.yr !== want.yr) report_mismatch("y_out", got.yr, want.yr);
          if (got.pc !== want.pc) report_mismatch("pc_out", got.pc, want.pc);
          if (got.n !== want.n) report_mismatch("neg_flag", got.n, want.n);
          if (got.z !== want.z) report_mismatch("zero_flag", got.z, want.z);
          if (got.c !== want.c) report_mismatch("carry_flag", got.c, want.c);
        end
        result_count++;
      end
      if (in_valid && !in_stall) begin
        apply_item(cmd, mem_addr, mem_data, want);
        result_q.push_back(want);
        item_count++;
        if (cmd == CMD_STEP) step_count++;
        if (want.status == STAT_OPCODE) opcode_errs++;
        if (want.status == STAT_FETCH) fetch_errs++;
      end
      pending = result_q.size();
    end
  end

endmodule

>>> bench/cpu_load_logic_compare_subset_tb.sv
// Testbench top: clock, reset, stimulus and verdict for the CPU subset.
`timescale 1ns / 1ps

module cpu_load_logic_compare_subset_tb;
  import clc_pkg::*;
  import clc_tb_pkg::*;

  localparam int MEM_BYTES      = 65536;
  // covers the memory clearing sweep after reset several times over
  localparam int WATCHDOG_LIMIT = 250000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd = '0;
  logic [15:0] mem_addr = '0;
  logic [7:0]  mem_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [7:0]  acc_out, x_out, y_out;
  logic [15:0] pc_out;
  logic        neg_flag, zero_flag, carry_flag;

  int fail_count, pending, item_count, step_count, opcode_errs, fetch_errs;
  int gap_pct = 0;
  int stall_pct = 0;
  int sent_count = 0;
  int idle_cycles = 0;
  logic [15:0] base_now = '0;

  always #5 clk = ~clk;

  cpu_load_logic_compare_subset #(.MEM_BYTES(MEM_BYTES)) DUT (.*);

  clc_state_tracker #(.MEM_BYTES(MEM_BYTES)) u_tracker (.*);

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer in %0d cycles", WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic apb_write(input logic [2:0] a, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] base, input logic [16:0] len);
    apb_write(REG_PROGRAM_BASE, {16'h0000, base});
    @(posedge clk);
    apb_write(REG_PROGRAM_LENGTH, {15'h0000, len});
    base_now = base;
  endtask

  task automatic send_item(input logic [1:0] c, input logic [15:0] a, input logic [7:0] d);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    mem_addr <= a;
    mem_data <= d;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  // writes operands and instructions at the program base, then starts and steps
  task automatic run_program();
    int          n;
    logic [15:0] pa, tgt;
    logic [7:0]  op, b0, b1, p_hi;
    op_decode_t  d;
    n  = $urandom_range(6, 1);
    pa = base_now;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0) begin
        op = 8'($urandom);
      end else begin
        do begin
          op = 8'($urandom);
          d  = decode_op(op);
        end while (!d.ok);
      end
      d  = decode_op(op);
      b0 = pick_byte();
      b1 = pick_byte();
      if (d.ok) begin
        case (d.mode)
          AM_ZP, AM_ZPX, AM_ZPY:    send_item(CMD_WRITE, {8'h00, b0}, pick_byte());
          AM_ABS, AM_ABSX, AM_ABSY: send_item(CMD_WRITE, {b1, b0}, pick_byte());
          AM_INDX, AM_INDY: begin
            tgt  = 16'($urandom);
            p_hi = b0 + 8'd1;
            send_item(CMD_WRITE, {8'h00, b0}, tgt[7:0]);
            send_item(CMD_WRITE, {8'h00, p_hi}, tgt[15:8]);
            send_item(CMD_WRITE, tgt, pick_byte());
          end
          default: ;
        endcase
      end
      send_item(CMD_WRITE, pa, op);
      pa = pa + 16'd1;
      send_item(CMD_WRITE, pa, b0);
      pa = pa + 16'd1;
      if (d.ok && is_absolute(d.mode)) begin
        send_item(CMD_WRITE, pa, b1);
        pa = pa + 16'd1;
      end
    end
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(2))
        0: send_item(CMD_UNUSED, 16'($urandom), 8'($urandom));
        1: send_item(CMD_WRITE, 16'($urandom), 8'($urandom));
        default: send_item(CMD_STEP, 16'($urandom), 8'($urandom));
      endcase
    end
    send_item(CMD_START, 16'($urandom), 8'($urandom));
    repeat (n + $urandom_range(1)) send_item(CMD_STEP, 16'($urandom), 8'($urandom));
  endtask

  task automatic run_phase(input logic [15:0] base, input logic [16:0] len,
                           input int gap, input int stall, input int quota);
    int target;
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    gap_pct   = gap;
    stall_pct = stall;
    repeat (8) @(posedge clk);
    set_config(base, len);
    target = sent_count + quota;
    while (sent_count < target) run_program();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    set_config(16'hFFFE, 17'h00020);

    // hand-built program across the top of memory, pc wrapping to zero
    send_item(CMD_UNUSED, 16'hFFFF, 8'hFF);
    send_item(CMD_STEP, 16'h0000, 8'h00);      // pc 0 holds zero: unknown opcode
    send_item(CMD_WRITE, 16'hFFFE, OP_LDX_IMM);
    send_item(CMD_WRITE, 16'hFFFF, 8'hFF);
    send_item(CMD_WRITE, 16'h0000, OP_LDA_ZPX);
    send_item(CMD_WRITE, 16'h0001, 8'h80);     // 0x80 + X wraps to 0x7F
    send_item(CMD_WRITE, 16'h007F, 8'h80);
    send_item(CMD_WRITE, 16'h0002, OP_CMP_IMM);
    send_item(CMD_WRITE, 16'h0003, 8'h80);     // equal compare
    send_item(CMD_WRITE, 16'h0004, OP_ORA_INDX);
    send_item(CMD_WRITE, 16'h0005, 8'h00);     // pointer at 0xFF, high byte from 0x00
    send_item(CMD_WRITE, 16'h00FF, 8'h34);
    send_item(CMD_WRITE, 16'h0006, OP_AND_IMM);
    send_item(CMD_WRITE, 16'h0007, 8'h00);
    send_item(CMD_WRITE, 16'h0008, OP_EOR_IMM);
    send_item(CMD_WRITE, 16'h0009, 8'hFF);
    send_item(CMD_START, 16'h5A5A, 8'hA5);
    repeat (7) send_item(CMD_STEP, 16'h0000, 8'h00);

    run_phase(16'h0200, 17'h00040,  0,  0, 300);
    run_phase(16'hFFFF, 17'h10000, 83,  0, 300);
    run_phase(16'h0000, 17'h00000,  0, 83, 150);
    run_phase(16'($urandom), 17'h00007, 28, 28, 300);
    run_phase(16'hFFF8, 17'h00030, 83, 83, 250);
    run_phase(16'h0000, 17'h10000,  0,  0, 300);
    run_phase(16'($urandom), 17'h00100, 28, 28, 330);

    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (40) @(posedge clk);

    $display("Checked %0d transfers, %0d of them steps (%0d unknown opcode, %0d past program end).",
             item_count, step_count, opcode_errs, fetch_errs);
    $display("Eight register settings from empty to full-length programs, five idling patterns.");
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/clc_pkg.sv
rtl/core/clc_mem.sv
rtl/core/cpu_load_logic_compare_subset.sv
bench/clc_state_tracker.sv
bench/cpu_load_logic_compare_subset_tb.sv
